// ===== rtl/core/tile_column_attribute_composer_unit_assert.svh =====
`ifndef TILE_COLUMN_ATTRIBUTE_COMPOSER_UNIT_ASSERT_SVH
`define TILE_COLUMN_ATTRIBUTE_COMPOSER_UNIT_ASSERT_SVH

// Checked property, off while reset is high.
`define TCAC_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked property, live through reset.
`define TCAC_CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/tcac_pkg.sv =====
`default_nettype none
package tcac_pkg;

   localparam int unsigned ROWS_DEFAULT = 14;
   localparam int unsigned ATTR_DEPTH   = 8;

   typedef enum logic [1:0] {
      CMD_START_FORWARD  = 2'd0,
      CMD_START_BACKWARD = 2'd1,
      CMD_METATILE       = 2'd2
   } command_type;

   localparam logic [7:0] MASK_FORWARD_KEEP  = 8'h33;
   localparam logic [7:0] MASK_BACKWARD_KEEP = 8'hCC;

endpackage
`default_nettype wire

// ===== rtl/core/tile_column_attribute_composer_unit.sv =====
`default_nettype none
// Tile column attribute composer. Start commands (forward or backward) open a new column:
// they flip the column parity, mask the 8-byte attribute store and produce no
// transaction on the rsp side. Each following metatile transaction, up to ROWS of them,
// ORs its palette into one attribute byte and returns one rsp transaction with the
// four tile buffer positions and the updated byte; further metatiles are dropped.
// Throughput is one transaction per cycle while rsp_stall is low. An accepted metatile
// passes from the input register to the result register, which raises rsp_valid; while
// rsp_stall holds a result, a metatile waiting behind it stalls req. csr_write_data is sampled
// live, so write it only while no transaction is in flight.
module tile_column_attribute_composer_unit #(
   parameter int unsigned ROWS = tcac_pkg::ROWS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_command,
   input  wire logic [7:0] req_tile_upper_left,
   input  wire logic [7:0] req_tile_upper_right,
   input  wire logic [7:0] req_tile_lower_left,
   input  wire logic [7:0] req_tile_lower_right,
   input  wire logic [1:0] req_palette,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_last_row,
   output logic [2:0]      rsp_attr_index,
   output logic [7:0]      rsp_attr_value,
   output logic [5:0]      rsp_pos_upper_left,
   output logic [7:0]      rsp_out_upper_left,
   output logic [5:0]      rsp_pos_upper_right,
   output logic [7:0]      rsp_out_upper_right,
   output logic [5:0]      rsp_pos_lower_left,
   output logic [7:0]      rsp_out_lower_left,
   output logic [5:0]      rsp_pos_lower_right,
   output logic [7:0]      rsp_out_lower_right,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_write_data
);

   localparam int unsigned CNT_W = $clog2(ROWS + 1);
   localparam logic [CNT_W-1:0] ROWS_CNT       = CNT_W'(ROWS);
   localparam logic [5:0]       POS_LOWER_BASE = 6'(2 * ROWS);
   localparam logic [5:0]       POS_UPPER_BACK = 6'(4 * ROWS - 2);
   localparam logic [5:0]       POS_LOWER_BACK = 6'(2 * ROWS - 2);
   localparam logic [5:0]       ATTR_ROW_BACK  = 6'(2 * ROWS + 1);

   logic             fix_ff, fix_in;
   logic             parity_ff, parity_in;
   logic             backward_ff, backward_in;
   logic [CNT_W-1:0] row_count_ff, row_count_in;
   logic [7:0]       attr_store_ff [tcac_pkg::ATTR_DEPTH];
   logic [7:0]       attr_store_in [tcac_pkg::ATTR_DEPTH];

   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_command_ff;
   logic [7:0] s1_ul_ff, s1_ur_ff, s1_ll_ff, s1_lr_ff;
   logic [1:0] s1_palette_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       last_row_ff;
   logic [2:0] attr_index_ff;
   logic [7:0] attr_value_ff;
   logic [5:0] pos_ul_ff, pos_ur_ff, pos_ll_ff, pos_lr_ff;
   logic [7:0] out_ul_ff, out_ur_ff, out_ll_ff, out_lr_ff;

   logic       is_item, produces, out_ready, s1_advance, req_accept;
   logic [5:0] m2, t, pos_ul, pos_ll;
   logic       p_back, start_parity, start_p;
   logic [2:0] shift;
   logic [2:0] idx;
   logic [7:0] new_byte, mask;
   logic [CNT_W-1:0] row_next;

   assign out_ready  = ~rsp_valid_ff | ~rsp_stall;
   assign is_item    = (s1_command_ff == tcac_pkg::CMD_METATILE) && (row_count_ff < ROWS_CNT);
   assign produces   = s1_valid_ff & is_item;
   assign s1_advance = s1_valid_ff & (~is_item | out_ready);
   assign req_stall  = s1_valid_ff & ~s1_advance;
   assign req_accept = req_valid & ~req_stall;

   assign m2       = 6'(row_count_ff) << 1;
   assign p_back   = parity_ff ^ fix_ff;
   assign row_next = row_count_ff + 1'b1;

   always_comb begin
      if (backward_ff) begin
         t      = ATTR_ROW_BACK - m2;
         pos_ul = POS_UPPER_BACK - m2;
         pos_ll = POS_LOWER_BACK - m2;
         shift  = {t[1], ~p_back, 1'b0};
      end else begin
         t      = 6'd2 + m2;
         pos_ul = m2;
         pos_ll = POS_LOWER_BASE + m2;
         shift  = {t[1], parity_ff, 1'b0};
      end
      idx      = t[4:2];
      new_byte = attr_store_ff[idx] | (8'(s1_palette_ff) << shift);
   end

   assign start_parity = ~parity_ff;
   assign start_p      = start_parity ^ fix_ff;

   always_comb begin
      fix_in       = csr_write_enable ? csr_write_data : fix_ff;
      parity_in    = parity_ff;
      backward_in  = backward_ff;
      row_count_in = row_count_ff;
      mask         = 8'hFF;
      for (int i = 0; i < tcac_pkg::ATTR_DEPTH; i++) begin
         attr_store_in[i] = attr_store_ff[i];
      end
      if (s1_advance) begin
         unique case (s1_command_ff) inside
            tcac_pkg::CMD_START_FORWARD, tcac_pkg::CMD_START_BACKWARD: begin
               parity_in    = start_parity;
               backward_in  = (s1_command_ff == tcac_pkg::CMD_START_BACKWARD);
               row_count_in = '0;
               if (s1_command_ff == tcac_pkg::CMD_START_BACKWARD) begin
                  mask = start_p ? tcac_pkg::MASK_BACKWARD_KEEP : 8'h00;
               end else begin
                  mask = start_parity ? tcac_pkg::MASK_FORWARD_KEEP : 8'h00;
               end
               for (int i = 0; i < tcac_pkg::ATTR_DEPTH; i++) begin
                  attr_store_in[i] = attr_store_ff[i] & mask;
               end
            end
            tcac_pkg::CMD_METATILE: begin
               if (is_item) begin
                  row_count_in       = row_next;
                  attr_store_in[idx] = new_byte;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = out_ready ? produces : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_ff       <= 1'b0;
         parity_ff    <= 1'b1;
         backward_ff  <= 1'b0;
         row_count_ff <= ROWS_CNT;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < tcac_pkg::ATTR_DEPTH; i++) begin
            attr_store_ff[i] <= 8'h00;
         end
      end else begin
         fix_ff       <= fix_in;
         parity_ff    <= parity_in;
         backward_ff  <= backward_in;
         row_count_ff <= row_count_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < tcac_pkg::ATTR_DEPTH; i++) begin
            attr_store_ff[i] <= attr_store_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_command_ff <= req_command;
         s1_ul_ff      <= req_tile_upper_left;
         s1_ur_ff      <= req_tile_upper_right;
         s1_ll_ff      <= req_tile_lower_left;
         s1_lr_ff      <= req_tile_lower_right;
         s1_palette_ff <= req_palette;
      end
      if (out_ready && produces) begin
         last_row_ff   <= (row_next == ROWS_CNT);
         attr_index_ff <= idx;
         attr_value_ff <= new_byte;
         pos_ul_ff     <= pos_ul;
         pos_ur_ff     <= pos_ul | 6'd1;
         pos_ll_ff     <= pos_ll;
         pos_lr_ff     <= pos_ll | 6'd1;
         out_ul_ff     <= s1_ul_ff;
         out_ur_ff     <= s1_ur_ff;
         out_ll_ff     <= s1_ll_ff;
         out_lr_ff     <= s1_lr_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_last_row        = last_row_ff;
   assign rsp_attr_index      = attr_index_ff;
   assign rsp_attr_value      = attr_value_ff;
   assign rsp_pos_upper_left  = pos_ul_ff;
   assign rsp_out_upper_left  = out_ul_ff;
   assign rsp_pos_upper_right = pos_ur_ff;
   assign rsp_out_upper_right = out_ur_ff;
   assign rsp_pos_lower_left  = pos_ll_ff;
   assign rsp_out_lower_left  = out_ll_ff;
   assign rsp_pos_lower_right = pos_lr_ff;
   assign rsp_out_lower_right = out_lr_ff;

endmodule
`default_nettype wire

// ===== rtl/core/tcac_checker.sv =====
`default_nettype none
`include "tile_column_attribute_composer_unit_assert.svh"
module tcac_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_last_row,
   input wire logic [2:0] rsp_attr_index,
   input wire logic [7:0] rsp_attr_value,
   input wire logic [5:0] rsp_pos_upper_left,
   input wire logic [7:0] rsp_out_upper_left,
   input wire logic [5:0] rsp_pos_upper_right,
   input wire logic [7:0] rsp_out_upper_right,
   input wire logic [5:0] rsp_pos_lower_left,
   input wire logic [7:0] rsp_out_lower_left,
   input wire logic [5:0] rsp_pos_lower_right,
   input wire logic [7:0] rsp_out_lower_right
);

   logic [67:0] rsp_payload;

   assign rsp_payload = {rsp_last_row, rsp_attr_index, rsp_attr_value,
                         rsp_pos_upper_left, rsp_out_upper_left,
                         rsp_pos_upper_right, rsp_out_upper_right,
                         rsp_pos_lower_left, rsp_out_lower_left,
                         rsp_pos_lower_right, rsp_out_lower_right};

   `TCAC_CHECK(a_rsp_hold,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload),
      "stalled rsp transaction changed")

   `TCAC_CHECK(a_upper_pair,
      rsp_valid |-> !rsp_pos_upper_left[0] && rsp_pos_upper_right == (rsp_pos_upper_left | 6'd1),
      "upper tile positions not an even/odd pair")

   `TCAC_CHECK(a_lower_pair,
      rsp_valid |-> !rsp_pos_lower_left[0] && rsp_pos_lower_right == (rsp_pos_lower_left | 6'd1),
      "lower tile positions not an even/odd pair")

   `TCAC_CHECK_ALWAYS(a_reset_idle, $past(reset) |-> !rsp_valid, "rsp_valid high right after reset")

endmodule

bind tile_column_attribute_composer_unit tcac_checker u_tcac_checker (.*);
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned ROWS = tcac_pkg::ROWS_DEFAULT;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int unsigned PHASES = 6;
   localparam int unsigned PHASE_GOAL = 100;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] tile_ul;
      logic [7:0] tile_ur;
      logic [7:0] tile_ll;
      logic [7:0] tile_lr;
      logic [1:0] palette;
   } metatile_req_type;

   typedef struct packed {
      logic       last_row;
      logic [2:0] attr_index;
      logic [7:0] attr_value;
      logic [5:0] pos_ul;
      logic [7:0] out_ul;
      logic [5:0] pos_ur;
      logic [7:0] out_ur;
      logic [5:0] pos_ll;
      logic [7:0] out_ll;
      logic [5:0] pos_lr;
      logic [7:0] out_lr;
   } column_result_type;

   typedef struct packed {
      metatile_req_type  item;
      logic [3:0]        reps;
      logic              typed;
      column_result_type golden;
   } script_row_type;

   localparam int unsigned SCRIPT_LEN = 24;
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      '{'{tcac_pkg::CMD_METATILE, 8'h11, 8'h22, 8'h33, 8'h44, 2'd1}, 4'd1, 1'b0, '0},
      '{'{CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3}, 4'd1, 1'b0, '0},
      '{'{tcac_pkg::CMD_START_FORWARD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3}, 4'd1, 1'b0, '0},
      '{'{tcac_pkg::CMD_METATILE, 8'h00, 8'hFF, 8'h00, 8'hFF, 2'd3}, 4'd1, 1'b1,
        '{1'b0, 3'd0, 8'h30, 6'd0, 8'h00, 6'd1, 8'hFF, 6'd28, 8'h00, 6'd29, 8'hFF}},
      '{'{tcac_pkg::CMD_METATILE, 8'hFF, 8'h00, 8'hFF, 8'h00, 2'd3}, 4'd1, 1'b1,
        '{1'b0, 3'd1, 8'h03, 6'd2, 8'hFF, 6'd3, 8'h00, 6'd30, 8'hFF, 6'd31, 8'h00}},
      '{'{tcac_pkg::CMD_METATILE, 8'h5A, 8'hA5, 8'h3C, 8'hC3, 2'd2}, 4'd11, 1'b0, '0},
      '{'{tcac_pkg::CMD_METATILE, 8'h80, 8'h01, 8'h7F, 8'hFE, 2'd2}, 4'd1, 1'b1,
        '{1'b1, 3'd7, 8'h02, 6'd26, 8'h80, 6'd27, 8'h01, 6'd54, 8'h7F, 6'd55, 8'hFE}},
      '{'{tcac_pkg::CMD_METATILE, 8'h11, 8'h22, 8'h33, 8'h44, 2'd1}, 4'd1, 1'b0, '0},
      '{'{tcac_pkg::CMD_START_BACKWARD, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0}, 4'd1, 1'b0, '0},
      '{'{tcac_pkg::CMD_METATILE, 8'hAA, 8'h55, 8'hCC, 8'h33, 2'd3}, 4'd1, 1'b1,
        '{1'b0, 3'd7, 8'h03, 6'd54, 8'hAA, 6'd55, 8'h55, 6'd26, 8'hCC, 6'd27, 8'h33}},
      '{'{tcac_pkg::CMD_METATILE, 8'h96, 8'h69, 8'hF0, 8'h0F, 2'd1}, 4'd12, 1'b0, '0},
      '{'{tcac_pkg::CMD_METATILE, 8'h01, 8'h02, 8'h04, 8'h08, 2'd1}, 4'd1, 1'b1,
        '{1'b1, 3'd0, 8'h10, 6'd28, 8'h01, 6'd29, 8'h02, 6'd0, 8'h04, 6'd1, 8'h08}},
      '{'{CMD_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0}, 4'd1, 1'b0, '0},
      '{'{tcac_pkg::CMD_START_FORWARD, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0}, 4'd1, 1'b0, '0},
      '{'{tcac_pkg::CMD_METATILE, 8'h10, 8'h20, 8'h40, 8'h80, 2'd0}, 4'd1, 1'b0, '0},
      '{'{tcac_pkg::CMD_START_BACKWARD, 8'hFF, 8'h00, 8'hFF, 8'h00, 2'd2}, 4'd1, 1'b0, '0},
      '{'{tcac_pkg::CMD_METATILE, 8'hC0, 8'h0C, 8'h30, 8'h03, 2'd2}, 4'd1, 1'b0, '0},
      '{'{tcac_pkg::CMD_METATILE, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0}, 4'd1, 1'b0, '0},
      '{'{tcac_pkg::CMD_START_FORWARD, 8'h55, 8'hAA, 8'h55, 8'hAA, 2'd1}, 4'd1, 1'b0, '0},
      '{'{tcac_pkg::CMD_METATILE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3}, 4'd1, 1'b0, '0},
      '{'{tcac_pkg::CMD_START_FORWARD, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0}, 4'd1, 1'b0, '0},
      '{'{tcac_pkg::CMD_METATILE, 8'hE7, 8'h7E, 8'h18, 8'h81, 2'd3}, 4'd2, 1'b0, '0},
      '{'{tcac_pkg::CMD_START_BACKWARD, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0}, 4'd1, 1'b0, '0},
      '{'{tcac_pkg::CMD_METATILE, 8'h3F, 8'hF3, 8'hCF, 8'hFC, 2'd3}, 4'd3, 1'b0, '0}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_command = '0;
   logic [7:0] req_tile_upper_left = '0;
   logic [7:0] req_tile_upper_right = '0;
   logic [7:0] req_tile_lower_left = '0;
   logic [7:0] req_tile_lower_right = '0;
   logic [1:0] req_palette = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_last_row;
   logic [2:0] rsp_attr_index;
   logic [7:0] rsp_attr_value;
   logic [5:0] rsp_pos_upper_left;
   logic [7:0] rsp_out_upper_left;
   logic [5:0] rsp_pos_upper_right;
   logic [7:0] rsp_out_upper_right;
   logic [5:0] rsp_pos_lower_left;
   logic [7:0] rsp_out_lower_left;
   logic [5:0] rsp_pos_lower_right;
   logic [7:0] rsp_out_lower_right;
   logic       csr_write_enable = 1'b0;
   logic       csr_write_data = 1'b0;

   logic       track_parity = 1'b1;
   logic [7:0] track_attr [tcac_pkg::ATTR_DEPTH];
   logic [3:0] track_row = 4'(ROWS);
   logic       track_backward = 1'b0;
   logic       track_fix = 1'b0;

   column_result_type pending_metatiles [$];
   int unsigned       mismatches = 0;
   int unsigned       transactions_done = 0;
   bit                steady = 1'b0;

   tile_column_attribute_composer_unit #(.ROWS(ROWS)) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_tile_upper_left  (req_tile_upper_left),
      .req_tile_upper_right (req_tile_upper_right),
      .req_tile_lower_left  (req_tile_lower_left),
      .req_tile_lower_right (req_tile_lower_right),
      .req_palette          (req_palette),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_last_row         (rsp_last_row),
      .rsp_attr_index       (rsp_attr_index),
      .rsp_attr_value       (rsp_attr_value),
      .rsp_pos_upper_left   (rsp_pos_upper_left),
      .rsp_out_upper_left   (rsp_out_upper_left),
      .rsp_pos_upper_right  (rsp_pos_upper_right),
      .rsp_out_upper_right  (rsp_out_upper_right),
      .rsp_pos_lower_left   (rsp_pos_lower_left),
      .rsp_out_lower_left   (rsp_out_lower_left),
      .rsp_pos_lower_right  (rsp_pos_lower_right),
      .rsp_out_lower_right  (rsp_out_lower_right),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic bit compose_metatile(input metatile_req_type it,
                                           output column_result_type res);
      int unsigned m;
      int unsigned t;
      int unsigned shift;
      logic        half;
      logic        bottom;
      logic [7:0]  mask;
      res = '0;
      half = track_parity ^ track_fix;
      if (it.command == tcac_pkg::CMD_START_FORWARD ||
          it.command == tcac_pkg::CMD_START_BACKWARD) begin
         track_parity = ~track_parity;
         track_backward = (it.command == tcac_pkg::CMD_START_BACKWARD);
         half = track_parity ^ track_fix;
         if (track_backward) begin
            mask = half ? tcac_pkg::MASK_BACKWARD_KEEP : 8'h00;
         end else begin
            mask = track_parity ? tcac_pkg::MASK_FORWARD_KEEP : 8'h00;
         end
         for (int i = 0; i < tcac_pkg::ATTR_DEPTH; i++) track_attr[i] &= mask;
         track_row = '0;
         return 1'b0;
      end
      if (it.command != tcac_pkg::CMD_METATILE || track_row >= ROWS) return 1'b0;
      m = track_row;
      if (!track_backward) begin
         t = 2 + 2 * m;
         bottom = t[1];
         shift = track_parity ? (bottom ? 6 : 2) : (bottom ? 4 : 0);
         res.pos_ul = 6'(2 * m);
         res.pos_ur = 6'(2 * m + 1);
         res.pos_ll = 6'(2 * ROWS + 2 * m);
         res.pos_lr = 6'(2 * ROWS + 2 * m + 1);
      end else begin
         t = 2 * ROWS + 1 - 2 * m;
         bottom = t[1];
         shift = half ? (bottom ? 4 : 0) : (bottom ? 6 : 2);
         res.pos_ul = 6'(4 * ROWS - 2 - 2 * m);
         res.pos_ur = 6'(4 * ROWS - 1 - 2 * m);
         res.pos_ll = 6'(2 * ROWS - 2 - 2 * m);
         res.pos_lr = 6'(2 * ROWS - 1 - 2 * m);
      end
      res.attr_index = t[4:2];
      track_attr[res.attr_index] = track_attr[res.attr_index] | (8'(it.palette) << shift);
      track_row = track_row + 4'd1;
      res.last_row = (track_row == ROWS);
      res.attr_value = track_attr[res.attr_index];
      res.out_ul = it.tile_ul;
      res.out_ur = it.tile_ur;
      res.out_ll = it.tile_ll;
      res.out_lr = it.tile_lr;
      return 1'b1;
   endfunction

   function automatic string show(input column_result_type r);
      return $sformatf("last=%0d attr[%0d]=%02h ul@%0d=%02h ur@%0d=%02h ll@%0d=%02h lr@%0d=%02h",
                       r.last_row, r.attr_index, r.attr_value, r.pos_ul, r.out_ul,
                       r.pos_ur, r.out_ur, r.pos_ll, r.out_ll, r.pos_lr, r.out_lr);
   endfunction

   function automatic metatile_req_type random_req();
      metatile_req_type it;
      it.command = 2'($urandom_range(0, 3));
      it.tile_ul = 8'($urandom);
      it.tile_ur = 8'($urandom);
      it.tile_ll = 8'($urandom);
      it.tile_lr = 8'($urandom);
      it.palette = 2'($urandom_range(0, 3));
      return it;
   endfunction

   always @(posedge clock) begin
      rsp_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 7);
   end

   always @(posedge clock) begin : check_rsp
      column_result_type seen;
      column_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{rsp_last_row, rsp_attr_index, rsp_attr_value,
                  rsp_pos_upper_left, rsp_out_upper_left, rsp_pos_upper_right,
                  rsp_out_upper_right, rsp_pos_lower_left, rsp_out_lower_left,
                  rsp_pos_lower_right, rsp_out_lower_right};
         if (pending_metatiles.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp transaction: %s", show(seen));
         end else begin
            want = pending_metatiles.pop_front();
            if (seen !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("rsp mismatch at %0t", $realtime);
                  $display("   expected %s", show(want));
                  $display("   actual   %s", show(seen));
               end
            end
         end
      end
   end

   task automatic issue(input metatile_req_type it, input bit typed,
                        input column_result_type golden);
      column_result_type predicted;
      if (!steady && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_command <= it.command;
      req_tile_upper_left <= it.tile_ul;
      req_tile_upper_right <= it.tile_ur;
      req_tile_lower_left <= it.tile_ll;
      req_tile_lower_right <= it.tile_lr;
      req_palette <= it.palette;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (compose_metatile(it, predicted)) begin
         pending_metatiles.push_back(typed ? golden : predicted);
      end
      transactions_done++;
   endtask

   task automatic write_fix(input logic value);
      req_valid <= 1'b0;
      while (pending_metatiles.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      track_fix = value;
   endtask

   task automatic random_column();
      metatile_req_type it;
      int unsigned      count;
      it = random_req();
      it.command = $urandom_range(0, 1) ? tcac_pkg::CMD_START_BACKWARD
                                        : tcac_pkg::CMD_START_FORWARD;
      issue(it, 1'b0, '0);
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ROWS + 3) : ROWS;
      repeat (count) begin
         it = random_req();
         it.command = ($urandom_range(0, 49) == 0) ? CMD_UNUSED : tcac_pkg::CMD_METATILE;
         issue(it, 1'b0, '0);
      end
   endtask

   initial begin
      int unsigned goal;
      for (int i = 0; i < tcac_pkg::ATTR_DEPTH; i++) track_attr[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      write_fix(1'b0);

      for (int r = 0; r < SCRIPT_LEN; r++) begin
         repeat (SCRIPT[r].reps) issue(SCRIPT[r].item, SCRIPT[r].typed, SCRIPT[r].golden);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         write_fix(ph < 4 ? logic'(~ph[0]) : logic'($urandom_range(0, 1)));
         steady = (ph == 2);
         goal = transactions_done + PHASE_GOAL;
         while (transactions_done < goal) begin
            if ($urandom_range(0, 99) < 88) begin
               random_column();
            end else begin
               issue(random_req(), 1'b0, '0);
            end
         end
      end
      steady = 1'b0;

      req_valid <= 1'b0;
      while (pending_metatiles.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
